// ===== design/adaptive_frame_skip_governor_assert.svh =====
`ifndef ADAPTIVE_FRAME_SKIP_GOVERNOR_ASSERT_SVH
`define ADAPTIVE_FRAME_SKIP_GOVERNOR_ASSERT_SVH
// Assertion helpers: implication checked on every edge outside reset.
`define AFSG_ASSERT_IMP(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("assertion failed");
`define AFSG_ASSERT_NXT(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// ===== design/afsg_pkg.sv =====
`default_nettype none
package afsg_pkg;
    localparam int PATTERN_LENGTH = 12;
    localparam int CADENCE_WINDOW = 24;
    localparam int COOLDOWN_LENGTH = 48;
    localparam logic [2:0] TOP_LEVEL = 3'd6;
    localparam logic [4:0] DETECT_MIN_TWOS = 5'd20;
    localparam logic [2:0] EXIT_ONES = 3'd4;
    localparam logic [31:0] GAP_LIMIT_US = 32'd250000;
    localparam logic [31:0] WINDOW_LIMIT_US = 32'd1500000;
    localparam logic [17:0] DOUBLE_STEP_BELOW = 18'd36045;
    localparam logic [17:0] SPEED_SAT = 18'd262143;
    localparam logic [17:0] SPEED_ONE = 18'd65536;
    // 12*65536*1e6/60
    localparam logic [37:0] SPEED_NUM = 38'd13107200000;

    localparam logic [1:0] FUNC_BEGIN = 2'd0;
    localparam logic [1:0] FUNC_END = 2'd1;
    localparam logic [1:0] FUNC_SUBMIT = 2'd2;
    localparam logic [1:0] MODE_FULL = 2'd1;
    localparam logic [1:0] MODE_BAL = 2'd2;

    localparam logic [2:0] REG_WARMUP = 3'd0;
    localparam logic [2:0] REG_AUD_LO = 3'd1;
    localparam logic [2:0] REG_AUD_HI = 3'd2;
    localparam logic [2:0] REG_RAISE = 3'd3;
    localparam logic [2:0] REG_LOWER = 3'd4;
    localparam logic [2:0] REG_BALMAX = 3'd5;

    typedef struct packed {
        logic [1:0]  func;
        logic [1:0]  mode;
        logic        enabled;
        logic [31:0] vb_count;
        logic [31:0] time_us;
        logic [6:0]  audio;
    } afsg_item_t;

    typedef struct packed {
        logic [4:0]  warmup_length;
        logic [6:0]  audio_low_mark;
        logic [6:0]  audio_high_mark;
        logic [16:0] raise_below_speed;
        logic [16:0] lower_above_speed;
        logic [2:0]  balanced_max_level;
    } afsg_cfg_t;

    typedef struct packed {
        logic load;      // capture item, run event step
        logic div_start; // begin speed division
        logic finish;    // apply window result
    } afsg_cmd_t;

    typedef struct packed {
        logic need_div;  // event closes a valid window
        logic div_done;
    } afsg_stat_t;

    function automatic logic skip_rom(input logic [2:0] lvl, input logic [3:0] slot);
        logic [11:0] r;
        case (lvl)
            3'd0: r = 12'h000;
            3'd1: r = 12'h800;
            3'd2: r = 12'h820;
            3'd3: r = 12'h888;
            3'd4: r = 12'h924;
            3'd5: r = 12'hA52;
            default: r = 12'hAAA;
        endcase
        skip_rom = (slot < 4'd12) ? r[slot] : 1'b0;
    endfunction
endpackage
`default_nettype wire

// ===== design/afsg_divider.sv =====
`default_nettype none
// Restoring divider, one quotient bit per cycle: q = (SPEED_NUM + e/2) / e.
module afsg_divider (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [31:0] divisor,
    output logic             done,
    output logic [17:0]      quotient
);
    logic [38:0] num_reg, num_next;
    logic [38:0] rem_reg, rem_next;
    logic [38:0] quo_reg, quo_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [39:0] trial;

    always_comb begin
        num_next = num_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        dvs_next = dvs_reg;
        trial = {rem_reg, num_reg[38]} - {8'd0, dvs_reg};
        if (start) begin
            num_next = {1'b0, afsg_pkg::SPEED_NUM} + {7'd0, 1'b0, divisor[31:1]};
            rem_next = '0;
            quo_next = '0;
            cnt_next = 6'd39;
            busy_next = 1'b1;
            dvs_next = divisor;
        end else if (busy_reg) begin
            num_next = {num_reg[37:0], 1'b0};
            if (!trial[39]) begin
                rem_next = trial[38:0];
                quo_next = {quo_reg[37:0], 1'b1};
            end else begin
                rem_next = {rem_reg[37:0], num_reg[38]};
                quo_next = {quo_reg[37:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
        num_reg <= num_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done = done_reg;
    assign quotient = (quo_reg > {21'd0, afsg_pkg::SPEED_SAT}) ? afsg_pkg::SPEED_SAT
                                                             : quo_reg[17:0];
endmodule
`default_nettype wire

// ===== design/afsg_datapath.sv =====
`default_nettype none
module afsg_datapath (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire afsg_pkg::afsg_cmd_t  cmd,
    output afsg_pkg::afsg_stat_t      stat,
    input  wire afsg_pkg::afsg_item_t item,
    input  wire afsg_pkg::afsg_cfg_t  cfg,
    output logic                      skip,
    output logic [2:0]                level,
    output logic                      native_lock,
    output logic                      active
);
    logic [17:0] avg_reg, avg_next;
    logic [2:0]  lvl_reg, lvl_next, saved_reg, saved_next, maxl_reg, maxl_next;
    logic [3:0]  slot_reg, slot_next, win_reg, win_next;
    logic [4:0]  warm_reg, warm_next;
    logic [1:0]  good_reg, good_next;
    logic        act_reg, act_next, hs_reg, hs_next, nat_reg, nat_next;
    logic [31:0] wst_reg, wst_next, lbt_reg, lbt_next, lvb_reg, lvb_next;
    logic [4:0]  smp_reg, smp_next, twos_reg, twos_next;
    logic [2:0]  ex_reg, ex_next;
    logic [5:0]  cd_reg, cd_next;
    logic        trk_reg, trk_next, hvb_reg, hvb_next, det_reg, det_next;
    logic        skip_reg, skip_next, need_reg, need_next;
    logic [6:0]  aud_reg, aud_next;
    logic [31:0] e_reg, e_next;

    logic [31:0] gap, e, dvb;
    logic [2:0]  bal;
    logic [17:0] m, av;
    logic [19:0] sum;
    logic [3:0]  lsum;
    logic        ddone;

    afsg_divider u_div (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.div_start),
        .divisor(e_reg), .done(ddone), .quotient(m)
    );

    always_comb begin
        avg_next = avg_reg; lvl_next = lvl_reg; saved_next = saved_reg;
        maxl_next = maxl_reg; slot_next = slot_reg; win_next = win_reg;
        warm_next = warm_reg; good_next = good_reg; act_next = act_reg;
        hs_next = hs_reg; nat_next = nat_reg; wst_next = wst_reg;
        lbt_next = lbt_reg; lvb_next = lvb_reg; smp_next = smp_reg;
        twos_next = twos_reg; ex_next = ex_reg; cd_next = cd_reg;
        trk_next = trk_reg; hvb_next = hvb_reg; det_next = det_reg;
        skip_next = skip_reg; need_next = need_reg; aud_next = aud_reg;
        e_next = e_reg;
        gap = item.time_us - lbt_reg;
        e = item.time_us - wst_reg;
        dvb = item.vb_count - lvb_reg;
        bal = (cfg.balanced_max_level > afsg_pkg::TOP_LEVEL) ? afsg_pkg::TOP_LEVEL
                                                              : cfg.balanced_max_level;
        sum = {2'd0, avg_reg} + {1'b0, avg_reg, 1'b0} + {2'd0, m} + 20'd2;
        av = hs_reg ? sum[19:2] : m;
        lsum = {1'b0, lvl_reg} + ((av < afsg_pkg::DOUBLE_STEP_BELOW) ? 4'd2 : 4'd1);

        if (cmd.load) begin
            skip_next = 1'b0;
            need_next = 1'b0;
            case (item.func)
                afsg_pkg::FUNC_BEGIN: begin
                    maxl_next = (item.mode == afsg_pkg::MODE_BAL) ? bal : afsg_pkg::TOP_LEVEL;
                    if (item.mode != afsg_pkg::MODE_FULL && item.mode != afsg_pkg::MODE_BAL) begin
                        if (act_reg) begin
                            avg_next = afsg_pkg::SPEED_ONE; lvl_next = '0; saved_next = '0;
                            slot_next = '0; warm_next = '0; win_next = '0; good_next = '0;
                            act_next = 1'b0; hs_next = 1'b0; nat_next = 1'b0;
                        end
                    end else if (!act_reg || gap[31] || gap > afsg_pkg::GAP_LIMIT_US) begin
                        avg_next = afsg_pkg::SPEED_ONE; lvl_next = '0; saved_next = '0;
                        slot_next = '0; warm_next = '0; win_next = '0; good_next = '0;
                        act_next = 1'b1; hs_next = 1'b0; nat_next = 1'b0;
                        wst_next = item.time_us; lbt_next = item.time_us;
                    end else begin
                        lbt_next = item.time_us;
                        if (det_reg && !nat_reg) begin
                            nat_next = 1'b1; saved_next = lvl_reg; lvl_next = '0;
                            slot_next = '0; good_next = '0;
                        end else if (!det_reg && nat_reg) begin
                            nat_next = 1'b0; lvl_next = saved_reg;
                            slot_next = '0; good_next = '0;
                        end
                        if (!det_reg && warm_reg >= cfg.warmup_length)
                            skip_next = afsg_pkg::skip_rom(
                                (nat_reg ? saved_reg : lvl_reg) > afsg_pkg::TOP_LEVEL
                                    ? afsg_pkg::TOP_LEVEL : (nat_reg ? saved_reg : lvl_reg),
                                nat_reg ? 4'd0 : slot_reg);
                    end
                end
                afsg_pkg::FUNC_END: begin
                    if (item.enabled && act_reg) begin
                        if (warm_reg < cfg.warmup_length) warm_next = warm_reg + 5'd1;
                        slot_next = (slot_reg == 4'd11) ? 4'd0 : slot_reg + 4'd1;
                        win_next = win_reg + 4'd1;
                        if (win_reg >= 4'd11) begin
                            wst_next = item.time_us;
                            win_next = '0;
                            if (e == '0 || e[31] || e > afsg_pkg::WINDOW_LIMIT_US) begin
                                hs_next = 1'b0; good_next = '0;
                            end else begin
                                need_next = 1'b1; e_next = e; aud_next = item.audio;
                            end
                        end
                    end
                end
                afsg_pkg::FUNC_SUBMIT: begin
                    if (!item.enabled) begin
                        if (trk_reg) begin
                            trk_next = 1'b0; hvb_next = 1'b0; det_next = 1'b0;
                            smp_next = '0; twos_next = '0; ex_next = '0; cd_next = '0;
                        end
                    end else begin
                        trk_next = 1'b1;
                        lvb_next = item.vb_count;
                        if (!hvb_reg) begin
                            hvb_next = 1'b1;
                        end else begin
                            if (cd_reg != '0) cd_next = cd_reg - 6'd1;
                            if (det_reg) begin
                                if (dvb == 32'd1) ex_next = ex_reg + 3'd1;
                                else if (dvb == 32'd2) ex_next = '0;
                                if (ex_next >= afsg_pkg::EXIT_ONES) begin
                                    smp_next = '0; twos_next = '0; ex_next = '0;
                                    cd_next = 6'(afsg_pkg::COOLDOWN_LENGTH);
                                    det_next = 1'b0;
                                end
                            end else begin
                                smp_next = smp_reg + 5'd1;
                                if (dvb == 32'd2) twos_next = twos_reg + 5'd1;
                                if (smp_next >= 5'(afsg_pkg::CADENCE_WINDOW)) begin
                                    if (cd_next == '0 && twos_next >= afsg_pkg::DETECT_MIN_TWOS)
                                        det_next = 1'b1;
                                    smp_next = '0; twos_next = '0;
                                end
                            end
                        end
                    end
                end
                default: ;
            endcase
        end else if (cmd.finish) begin
            need_next = 1'b0;
            avg_next = av;
            hs_next = 1'b1;
            if (warm_reg >= cfg.warmup_length) begin
                if (nat_reg) begin
                    lvl_next = '0; good_next = '0;
                end else if (av < {1'b0, cfg.raise_below_speed} ||
                             (aud_reg <= cfg.audio_low_mark &&
                              av < {1'b0, cfg.lower_above_speed})) begin
                    lvl_next = (lsum < {1'b0, maxl_reg}) ? lsum[2:0] : maxl_reg;
                    good_next = '0; slot_next = '0;
                end else if (av > {1'b0, cfg.lower_above_speed} &&
                             aud_reg >= cfg.audio_high_mark) begin
                    if (good_reg == 2'd2) begin
                        if (lvl_reg != '0) lvl_next = lvl_reg - 3'd1;
                        good_next = '0; slot_next = '0;
                    end else begin
                        good_next = good_reg + 2'd1;
                    end
                end else begin
                    good_next = '0;
                end
            end
        end
    end

    // av is the updated average; the first sample takes m itself
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            avg_reg <= afsg_pkg::SPEED_ONE; lvl_reg <= '0; saved_reg <= '0;
            maxl_reg <= afsg_pkg::TOP_LEVEL; slot_reg <= '0; win_reg <= '0;
            warm_reg <= '0; good_reg <= '0; act_reg <= 1'b0; hs_reg <= 1'b0;
            nat_reg <= 1'b0; wst_reg <= '0; lbt_reg <= '0; lvb_reg <= '0;
            smp_reg <= '0; twos_reg <= '0; ex_reg <= '0; cd_reg <= '0;
            trk_reg <= 1'b0; hvb_reg <= 1'b0; det_reg <= 1'b0;
            skip_reg <= 1'b0; need_reg <= 1'b0;
        end else begin
            avg_reg <= avg_next; lvl_reg <= lvl_next; saved_reg <= saved_next;
            maxl_reg <= maxl_next; slot_reg <= slot_next; win_reg <= win_next;
            warm_reg <= warm_next; good_reg <= good_next; act_reg <= act_next;
            hs_reg <= hs_next; nat_reg <= nat_next; wst_reg <= wst_next;
            lbt_reg <= lbt_next; lvb_reg <= lvb_next; smp_reg <= smp_next;
            twos_reg <= twos_next; ex_reg <= ex_next; cd_reg <= cd_next;
            trk_reg <= trk_next; hvb_reg <= hvb_next; det_reg <= det_next;
            skip_reg <= skip_next; need_reg <= need_next;
        end
        aud_reg <= aud_next;
        e_reg <= e_next;
    end

    assign stat.need_div = need_reg;
    assign stat.div_done = ddone;
    assign skip = skip_reg;
    assign level = lvl_reg;
    assign native_lock = nat_reg;
    assign active = act_reg;
endmodule
`default_nettype wire

// ===== design/afsg_ctrl.sv =====
`default_nettype none
`include "adaptive_frame_skip_governor_assert.svh"
module afsg_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_fire,
    input  wire logic                out_busy,
    input  wire afsg_pkg::afsg_stat_t stat,
    output afsg_pkg::afsg_cmd_t      cmd,
    output logic                     in_ready,
    output logic                     out_load
);
    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_EVAL = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_FIN  = 5'b01000,
        ST_OUT  = 5'b10000
    } afsg_state_t;
    afsg_state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        out_load = 1'b0;
        case (state_reg)
            ST_IDLE: if (in_fire) begin
                cmd.load = 1'b1;
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                if (stat.need_div) begin
                    cmd.div_start = 1'b1;
                    state_next = ST_DIV;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_DIV: if (stat.div_done) state_next = ST_FIN;
            ST_FIN: begin
                cmd.finish = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: if (!out_busy) begin
                out_load = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else state_reg <= state_next;
    end

    assign in_ready = (state_reg == ST_IDLE);

    `AFSG_ASSERT_NXT(a_load_eval, aclk, aresetn, cmd.load, state_reg == ST_EVAL)
    `AFSG_ASSERT_IMP(a_start_eval, aclk, aresetn, cmd.div_start, state_reg == ST_EVAL)
    `AFSG_ASSERT_NXT(a_fin_out, aclk, aresetn, cmd.finish, state_reg == ST_OUT)
endmodule
`default_nettype wire

// ===== design/adaptive_frame_skip_governor.sv =====
// Adaptive frame-skip governor.
// Input channel s_axis_*: one word per event (frame begin, frame end, render
// submission). Output channel m_axis_*: one word per event with the skip
// decision, current level, native-30 flag and active flag.
// Most events go from accept to output valid through the EVAL and OUT states; a
// frame end that closes a valid 12-frame window also runs the speed division in
// the restoring divider, with start and done handoff, through the DIV and FIN states.
// One event is processed at a time; s_axis_tready is high only when the
// controller is idle.
// The output register holds a finished word while the receiver stalls; the
// next event is accepted meanwhile and waits only at its own output step.
// Reset (aresetn low, synchronous) loads the register defaults, clears all
// governor and cadence state and empties the output register.
// Configuration goes through the APB port, registers at 4*index; write only
// while no event is in flight.
`default_nettype none
module adaptive_frame_skip_governor (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [1:0] func, [3:2] mode, [4] enabled, [5] rendered, [37:6] vb_count,
    // [69:38] time_us, [76:70] audio_fill, [79:77] zero
    input  wire logic [79:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [0] skip, [3:1] level, [4] native_lock, [5] active, [7:6] zero
    output logic [7:0]       m_axis_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    afsg_pkg::afsg_cfg_t  cfg_reg;
    afsg_pkg::afsg_item_t item;
    afsg_pkg::afsg_cmd_t  cmd;
    afsg_pkg::afsg_stat_t stat;
    logic       in_fire, out_load, skip, native, act;
    logic [2:0] level;
    logic       ov_reg;
    logic [7:0] od_reg;
    logic [2:0] ridx;

    assign pready = 1'b1;
    assign ridx = paddr[4:2];
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.warmup_length <= 5'd24;
            cfg_reg.audio_low_mark <= 7'd12;
            cfg_reg.audio_high_mark <= 7'd35;
            cfg_reg.raise_below_speed <= 17'd63570;
            cfg_reg.lower_above_speed <= 17'd65208;
            cfg_reg.balanced_max_level <= 3'd4;
        end else if (psel && penable && pwrite) begin
            case (ridx)
                afsg_pkg::REG_WARMUP: cfg_reg.warmup_length <= pwdata[4:0];
                afsg_pkg::REG_AUD_LO: cfg_reg.audio_low_mark <= pwdata[6:0];
                afsg_pkg::REG_AUD_HI: cfg_reg.audio_high_mark <= pwdata[6:0];
                afsg_pkg::REG_RAISE: cfg_reg.raise_below_speed <= pwdata[16:0];
                afsg_pkg::REG_LOWER: cfg_reg.lower_above_speed <= pwdata[16:0];
                afsg_pkg::REG_BALMAX: cfg_reg.balanced_max_level <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (ridx)
            afsg_pkg::REG_WARMUP: prdata = {27'd0, cfg_reg.warmup_length};
            afsg_pkg::REG_AUD_LO: prdata = {25'd0, cfg_reg.audio_low_mark};
            afsg_pkg::REG_AUD_HI: prdata = {25'd0, cfg_reg.audio_high_mark};
            afsg_pkg::REG_RAISE: prdata = {15'd0, cfg_reg.raise_below_speed};
            afsg_pkg::REG_LOWER: prdata = {15'd0, cfg_reg.lower_above_speed};
            afsg_pkg::REG_BALMAX: prdata = {29'd0, cfg_reg.balanced_max_level};
            default: prdata = '0;
        endcase
    end

    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign item.func = s_axis_tdata[1:0];
    assign item.mode = s_axis_tdata[3:2];
    assign item.enabled = s_axis_tdata[4];
    assign item.vb_count = s_axis_tdata[37:6];
    assign item.time_us = s_axis_tdata[69:38];
    assign item.audio = s_axis_tdata[76:70];

    afsg_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_fire(in_fire),
        .out_busy(ov_reg && !m_axis_tready), .stat(stat), .cmd(cmd),
        .in_ready(s_axis_tready), .out_load(out_load)
    );

    afsg_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat), .item(item),
        .cfg(cfg_reg), .skip(skip), .level(level), .native_lock(native),
        .active(act)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) ov_reg <= 1'b0;
        else if (out_load) ov_reg <= 1'b1;
        else if (m_axis_tready) ov_reg <= 1'b0;
        if (out_load) od_reg <= {2'b00, act, native, level, skip};
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata = od_reg;
endmodule
`default_nettype wire

// ===== dv/tb.sv =====
`default_nettype none
module tb;
    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [1:0] func, [3:2] mode, [4] enabled, [5] rendered, [37:6] vb_count,
    // [69:38] time_us, [76:70] audio_fill, [79:77] zero
    logic [79:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [0] skip, [3:1] level, [4] native_lock, [5] active, [7:6] zero
    logic [7:0]  m_axis_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    adaptive_frame_skip_governor i_dut (.*);

    always #1 aclk = ~aclk;

    localparam logic [1:0] FUNC_BAD = 2'd3;
    localparam logic [1:0] MODE_OFF = 2'd0;
    localparam logic [1:0] MODE_BAD = 2'd3;

    logic [79:0] pending_words[$];
    logic [7:0]  expected_words[$];
    int          errors = 0;
    int          words_checked = 0;
    int unsigned cycles = 0;

    // governor model state
    logic [4:0]  g_warm_len;
    logic [6:0]  g_aud_lo, g_aud_hi;
    logic [16:0] g_raise, g_lower;
    logic [2:0]  g_balmax;
    logic [17:0] g_avg;
    logic [2:0]  g_level, g_saved, g_max;
    logic [3:0]  g_slot, g_win;
    logic [4:0]  g_warm;
    logic [1:0]  g_good;
    logic        g_active, g_have, g_native;
    logic [31:0] g_win_start, g_last_bound, g_last_vb;
    int unsigned g_samples, g_twos, g_exits, g_cool;
    logic        g_tracking, g_have_vb, g_detected;

    function automatic void gov_clear();
        g_avg = afsg_pkg::SPEED_ONE; g_level = 0; g_saved = 0; g_slot = 0;
        g_warm = 0; g_win = 0; g_good = 0;
        g_active = 0; g_have = 0; g_native = 0;
    endfunction

    function automatic void gov_reset();
        g_warm_len = 24; g_aud_lo = 12; g_aud_hi = 35;
        g_raise = 63570; g_lower = 65208; g_balmax = 4;
        gov_clear();
        g_max = afsg_pkg::TOP_LEVEL;
        g_tracking = 0; g_have_vb = 0; g_detected = 0;
        g_win_start = 0; g_last_bound = 0; g_last_vb = 0;
        g_samples = 0; g_twos = 0; g_exits = 0; g_cool = 0;
    endfunction

    function automatic void gov_start(input logic [31:0] now);
        gov_clear();
        g_active = 1;
        g_win_start = now;
        g_last_bound = now;
    endfunction

    function automatic logic gov_begin(input logic [1:0] mode, input logic [31:0] now);
        logic [31:0] gap;
        logic [11:0] pat;
        g_max = (mode == afsg_pkg::MODE_BAL)
                ? ((g_balmax > afsg_pkg::TOP_LEVEL) ? afsg_pkg::TOP_LEVEL : g_balmax)
                : afsg_pkg::TOP_LEVEL;
        if (mode != afsg_pkg::MODE_FULL && mode != afsg_pkg::MODE_BAL) begin
            if (g_active) gov_clear();
            return 1'b0;
        end
        if (!g_active) begin
            gov_start(now);
            return 1'b0;
        end
        gap = now - g_last_bound;
        g_last_bound = now;
        if (gap[31] || gap > afsg_pkg::GAP_LIMIT_US) begin
            gov_start(now);
            return 1'b0;
        end
        if (g_detected && !g_native) begin
            g_native = 1; g_saved = g_level; g_level = 0; g_slot = 0; g_good = 0;
        end else if (!g_detected && g_native) begin
            g_native = 0; g_level = g_saved; g_slot = 0; g_good = 0;
        end
        if (g_native || g_warm < g_warm_len || g_slot >= 12) return 1'b0;
        case ((g_level > afsg_pkg::TOP_LEVEL) ? afsg_pkg::TOP_LEVEL : g_level)
            3'd0: pat = 12'h000;
            3'd1: pat = 12'h800;
            3'd2: pat = 12'h820;
            3'd3: pat = 12'h888;
            3'd4: pat = 12'h924;
            3'd5: pat = 12'hA52;
            default: pat = 12'hAAA;
        endcase
        return pat[g_slot];
    endfunction

    function automatic void gov_window(input logic [31:0] now, input logic [6:0] aud);
        logic [31:0] e;
        logic [63:0] m;
        logic [3:0]  lvl;
        e = now - g_win_start;
        g_win_start = now;
        g_win = 0;
        if (e == 0 || e[31] || e > afsg_pkg::WINDOW_LIMIT_US) begin
            g_have = 0; g_good = 0;
            return;
        end
        m = (64'd13107200000 + 64'(e / 2)) / 64'(e);
        if (m > afsg_pkg::SPEED_SAT) m = 64'(afsg_pkg::SPEED_SAT);
        if (!g_have) begin
            g_avg = m[17:0];
            g_have = 1;
        end else begin
            g_avg = 18'((3 * 64'(g_avg) + m + 2) >> 2);
        end
        if (g_warm < g_warm_len) return;
        if (g_native) begin
            g_level = 0; g_good = 0;
            return;
        end
        if (g_avg < g_raise || (aud <= g_aud_lo && g_avg < g_lower)) begin
            lvl = {1'b0, g_level} + ((g_avg < afsg_pkg::DOUBLE_STEP_BELOW) ? 4'd2 : 4'd1);
            g_level = (lvl < {1'b0, g_max}) ? lvl[2:0] : g_max;
            g_good = 0; g_slot = 0;
        end else if (g_avg > g_lower && aud >= g_aud_hi) begin
            g_good++;
            if (g_good >= 3) begin
                if (g_level > 0) g_level--;
                g_good = 0; g_slot = 0;
            end
        end else begin
            g_good = 0;
        end
    endfunction

    function automatic void gov_submit(input logic en, input logic [31:0] vb);
        logic [31:0] d;
        if (!en) begin
            if (g_tracking) begin
                g_tracking = 0; g_have_vb = 0; g_detected = 0;
                g_samples = 0; g_twos = 0; g_exits = 0; g_cool = 0;
            end
            return;
        end
        g_tracking = 1;
        if (!g_have_vb) begin
            g_last_vb = vb; g_have_vb = 1;
            return;
        end
        d = vb - g_last_vb;
        g_last_vb = vb;
        if (g_cool > 0) g_cool--;
        if (g_detected) begin
            if (d == 1) g_exits++;
            else if (d == 2) g_exits = 0;
            if (g_exits >= afsg_pkg::EXIT_ONES) begin
                g_samples = 0; g_twos = 0; g_exits = 0;
                g_cool = afsg_pkg::COOLDOWN_LENGTH; g_detected = 0;
            end
            return;
        end
        g_samples++;
        if (d == 2) g_twos++;
        if (g_samples < afsg_pkg::CADENCE_WINDOW) return;
        if (g_cool == 0 && g_twos >= afsg_pkg::DETECT_MIN_TWOS) g_detected = 1;
        g_samples = 0; g_twos = 0;
    endfunction

    function automatic logic [7:0] gov_event(input logic [79:0] w);
        logic skip;
        skip = 1'b0;
        case (w[1:0])
            afsg_pkg::FUNC_BEGIN: skip = gov_begin(w[3:2], w[69:38]);
            afsg_pkg::FUNC_END: begin
                if (w[4] && g_active) begin
                    if (g_warm < g_warm_len) g_warm++;
                    g_slot = (g_slot == 4'd11) ? 4'd0 : g_slot + 4'd1;
                    g_win++;
                    if (g_win >= 12) gov_window(w[69:38], w[76:70]);
                end
            end
            afsg_pkg::FUNC_SUBMIT: gov_submit(w[4], w[37:6]);
            default: ;
        endcase
        return {2'b00, g_active, g_native, g_level, skip};
    endfunction

    // input side
    int  s_gap = 0;
    bit  s_burst = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready)
                expected_words.push_back(gov_event(s_axis_tdata));
            if (!(s_axis_tvalid && !s_axis_tready)) begin
                if (s_gap > 0) begin
                    s_gap <= s_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    s_axis_tdata <= pending_words.pop_front();
                    s_axis_tvalid <= 1'b1;
                    if ($urandom_range(0, 99) < 3) s_burst <= ~s_burst;
                    if (!s_burst && $urandom_range(0, 9) < 3)
                        s_gap <= ($urandom_range(0, 9) < 9) ? $urandom_range(1, 3)
                                                            : $urandom_range(10, 60);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result side
    int  m_gap = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected word %h", $time, m_axis_tdata);
                    errors++;
                end else begin
                    logic [7:0] exp_w;
                    exp_w = expected_words.pop_front();
                    words_checked++;
                    if (exp_w[5:0] !== m_axis_tdata[5:0])
                        $display("%0t: mismatch exp skip %b level %0d native %b active %b, got skip %b level %0d native %b active %b",
                                 $time, exp_w[0], exp_w[3:1], exp_w[4], exp_w[5],
                                 m_axis_tdata[0], m_axis_tdata[3:1], m_axis_tdata[4],
                                 m_axis_tdata[5]);
                    if (exp_w[5:0] !== m_axis_tdata[5:0]) errors++;
                end
            end
            if (m_gap > 0) begin
                m_gap <= m_gap - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 9) < 3)
                    m_gap <= ($urandom_range(0, 9) < 9) ? $urandom_range(1, 3)
                                                        : $urandom_range(10, 60);
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 3000000) begin
            $display("tb: errors");
            $finish;
        end
    end

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        @(posedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            afsg_pkg::REG_WARMUP: g_warm_len = val[4:0];
            afsg_pkg::REG_AUD_LO: g_aud_lo = val[6:0];
            afsg_pkg::REG_AUD_HI: g_aud_hi = val[6:0];
            afsg_pkg::REG_RAISE:  g_raise = val[16:0];
            afsg_pkg::REG_LOWER:  g_lower = val[16:0];
            default:              g_balmax = val[2:0];
        endcase
    endtask

    task automatic write_all(input logic [31:0] w, lo, hi, rs, lw, bm);
        reg_write(afsg_pkg::REG_WARMUP, w);
        reg_write(afsg_pkg::REG_AUD_LO, lo);
        reg_write(afsg_pkg::REG_AUD_HI, hi);
        reg_write(afsg_pkg::REG_RAISE, rs);
        reg_write(afsg_pkg::REG_LOWER, lw);
        reg_write(afsg_pkg::REG_BALMAX, bm);
    endtask

    function automatic void add_word(input logic [1:0] f, m, input logic en, rend,
                                     input logic [31:0] vb, t, input logic [6:0] aud);
        pending_words.push_back({3'b000, aud, t, vb, rend, en, m, f});
    endfunction

    logic [31:0] now_us, vb_cnt;

    // mostly well-formed frames, with cadence and timing disturbances mixed in
    task automatic gen_frames(input int n);
        int p, k, vstep;
        logic [1:0] md;
        logic [6:0] aud;
        k = 0;
        while (k < n) begin
            case ($urandom_range(0, 5))
                0: p = $urandom_range(14000, 15500);
                1: p = $urandom_range(16000, 17500);
                2: p = $urandom_range(19000, 27000);
                3: p = $urandom_range(30000, 60000);
                4: p = $urandom_range(1, 3000);
                default: p = $urandom_range(14000, 30000);
            endcase
            md = ($urandom_range(0, 1)) ? afsg_pkg::MODE_FULL : afsg_pkg::MODE_BAL;
            vstep = ($urandom_range(0, 1)) ? 2 : 1;
            aud = 7'($urandom_range(0, 100));
            for (int i = 0; i < 36 && k < n; i++) begin
                if ($urandom_range(0, 9) == 0) aud = 7'($urandom_range(0, 100));
                if ($urandom_range(0, 99) == 0) aud = 7'($urandom_range(101, 127));
                if ($urandom_range(0, 199) == 0) now_us += $urandom_range(250001, 400000);
                if ($urandom_range(0, 199) == 0) now_us -= $urandom_range(1, 100000);
                if ($urandom_range(0, 299) == 0) now_us = $urandom;
                add_word(afsg_pkg::FUNC_BEGIN, ($urandom_range(0, 99) < 2) ? MODE_BAD : md,
                         1'($urandom), 1'($urandom), $urandom, now_us, 7'($urandom));
                vb_cnt += ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : vstep;
                add_word(afsg_pkg::FUNC_SUBMIT, 2'($urandom), $urandom_range(0, 99) != 0,
                         1'($urandom), ($urandom_range(0, 499) == 0) ? $urandom : vb_cnt,
                         $urandom, 7'($urandom));
                now_us += p;
                add_word(afsg_pkg::FUNC_END, 2'($urandom), $urandom_range(0, 49) != 0,
                         1'($urandom), $urandom, now_us, aud);
                if ($urandom_range(0, 99) == 0)
                    add_word($urandom_range(0, 99) < 50 ? FUNC_BAD : afsg_pkg::FUNC_BEGIN,
                             $urandom_range(0, 1) ? MODE_OFF : MODE_BAD,
                             1'($urandom), 1'($urandom), $urandom, $urandom, 7'($urandom));
                k += 3;
            end
        end
    endtask

    task automatic drain();
        while (pending_words.size() > 0 || s_axis_tvalid || expected_words.size() > 0)
            @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    initial begin
        gov_reset();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        now_us = $urandom;
        vb_cnt = $urandom;

        // directed: odd kinds, off/unknown modes, field extremes
        write_all(0, 12, 35, 63570, 65208, 4);
        add_word(FUNC_BAD, MODE_BAD, 1, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'h7F);
        add_word(afsg_pkg::FUNC_BEGIN, MODE_BAD, 1, 1, 0, 0, 0);
        add_word(afsg_pkg::FUNC_BEGIN, afsg_pkg::MODE_FULL, 0, 0, 0, 32'hFFFF_FFF0, 0);
        add_word(afsg_pkg::FUNC_BEGIN, afsg_pkg::MODE_FULL, 0, 0, 0, 32'h0000_1000, 0);
        add_word(afsg_pkg::FUNC_END, MODE_OFF, 1, 1, 0, 32'h0000_2000, 100);
        add_word(afsg_pkg::FUNC_BEGIN, afsg_pkg::MODE_BAL, 1, 0, 0, 32'h0000_0F00, 0);
        add_word(afsg_pkg::FUNC_BEGIN, afsg_pkg::MODE_BAL, 1, 0, 0, 32'h0004_0000, 0);
        add_word(afsg_pkg::FUNC_SUBMIT, MODE_OFF, 1, 0, 32'hFFFF_FFFF, 0, 0);
        add_word(afsg_pkg::FUNC_SUBMIT, MODE_OFF, 1, 0, 32'h0000_0001, 0, 0);
        add_word(afsg_pkg::FUNC_SUBMIT, MODE_OFF, 0, 0, 0, 0, 0);
        add_word(afsg_pkg::FUNC_END, MODE_OFF, 0, 0, 0, 0, 0);
        for (int i = 0; i < 12; i++)
            add_word(afsg_pkg::FUNC_END, MODE_OFF, 1, 0, 0, 32'h0004_0000, 7'h7F);
        add_word(afsg_pkg::FUNC_BEGIN, MODE_OFF, 1, 1, 0, 0, 0);
        gen_frames(200);
        drain();

        write_all(24, 12, 35, 63570, 65208, 4);
        gen_frames(250);
        drain();

        write_all(31, 100, 0, 131071, 0, 7);
        gen_frames(200);
        drain();

        write_all(0, 0, 0, 0, 0, 0);
        gen_frames(200);
        drain();

        write_all($urandom_range(0, 8), $urandom_range(5, 40), $urandom_range(20, 60),
                  $urandom_range(50000, 70000), $urandom_range(60000, 75000),
                  $urandom_range(0, 7));
        gen_frames(300);
        drain();

        $display("tb: %0d result words checked over five register settings", words_checked);
        $display("tb: frame, submission and cadence traffic with timing gaps and stalls");
        if (errors == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end
endmodule
`default_nettype wire
